// File: rtl/imu_window_median_tilt_defines.svh
// Assertion macros shared by the window median filter.
`ifndef IMU_WINDOW_MEDIAN_TILT_DEFINES_SVH
`define IMU_WINDOW_MEDIAN_TILT_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define IWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
// Assert that an expression holds at every edge out of reset.
`define IWM_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`endif

// File: rtl/iwm_pkg.sv
// Package with types, constants and the sequencer states of the median filter.
package iwm_pkg;
   localparam int WINDOW_DEFAULT = 30;
   localparam int FIELD_W = 16;
   localparam int SAMPLE_W = 6 * FIELD_W;
   localparam int KEY_W = 19;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_XY_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_Z_FLOOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_THRESHOLD = 2'd2;
   localparam logic [14:0] TILT_XY_LIMIT_RESET = 15'd15000;
   localparam logic signed [15:0] TILT_Z_FLOOR_RESET = 16'sd1000;
   localparam logic [14:0] TURN_THRESHOLD_RESET = 15'd2000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OUTER,
      ST_INNER,
      ST_FETCH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] accel_x;
      logic signed [FIELD_W-1:0] accel_y;
      logic signed [FIELD_W-1:0] accel_z;
      logic signed [FIELD_W-1:0] gyro_x;
      logic signed [FIELD_W-1:0] gyro_y;
      logic signed [FIELD_W-1:0] gyro_z;
   } sample_type;

   typedef struct packed {
      logic        ready_res;
      logic signed [FIELD_W-1:0] med_accel_x;
      logic signed [FIELD_W-1:0] med_accel_y;
      logic signed [FIELD_W-1:0] med_accel_z;
      logic signed [FIELD_W-1:0] med_gyro_x;
      logic signed [FIELD_W-1:0] med_gyro_y;
      logic signed [FIELD_W-1:0] med_gyro_z;
      logic        tilt;
      logic        turning;
   } result_type;

   // Full-width key: exact sum of the six signed fields.
   function automatic logic signed [KEY_W-1:0] key_of(input sample_type s);
      key_of = KEY_W'(s.accel_x) + KEY_W'(s.accel_y) + KEY_W'(s.accel_z)
             + KEY_W'(s.gyro_x) + KEY_W'(s.gyro_y) + KEY_W'(s.gyro_z);
   endfunction
endpackage

// File: rtl/iwm_stream_if.sv
// Valid/ready channel carrying one payload item.
interface iwm_stream_if #(parameter type PAYLOAD_TYPE = logic);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/iwm_ram.sv
// Generic single-port-write RAM with one registered read port.
module iwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/iwm_flags.sv
// Tilt and turning decision for the selected median sample.
module iwm_flags (
   input  iwm_pkg::sample_type       sample,
   input  logic [14:0]               tilt_xy_limit,
   input  logic signed [15:0]        tilt_z_floor,
   input  logic [14:0]               turn_threshold,
   output logic                      tilt,
   output logic                      turning
);
   logic signed [16:0] lim;
   logic signed [16:0] neg_lim;
   logic signed [16:0] ax;
   logic signed [16:0] ay;
   logic signed [16:0] gz;
   logic [16:0]        gz_mag;

   // Compare in 17 bits so the negated limit and |-32768| stay exact.
   always_comb begin
      lim = signed'({2'b00, tilt_xy_limit});
      neg_lim = -lim;
      ax = 17'(sample.accel_x);
      ay = 17'(sample.accel_y);
      gz = 17'(sample.gyro_z);
      gz_mag = gz[16] ? 17'(-gz) : 17'(gz);
      tilt = (ax < neg_lim) || (ax > lim) || (ay < neg_lim) || (ay > lim)
          || (sample.accel_z < tilt_z_floor);
      turning = gz_mag >= {2'b00, turn_threshold};
   end
endmodule

// File: rtl/imu_window_median_tilt.sv
// Top level of the sliding-window median filter with tilt and turning flags.
// Each item is one six-axis sample; it is written into a WINDOW-entry store and
// produces exactly one result. Until WINDOW samples have arrived the result is
// all zero, and such an item goes from idle straight to the result state. With
// a full window the median is found by ranking: for each candidate age a, one
// shared compare unit walks all WINDOW ages b, reading keys one per cycle
// through the single read port of a key RAM. The block takes no item while busy.
// A result already waiting does not stop the next item from being accepted, but
// that item's result waits until the previous one has been taken, and every
// cycle of that wait adds to the item's time.
`include "imu_window_median_tilt_defines.svh"
module imu_window_median_tilt #(
   parameter int WINDOW = iwm_pkg::WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   iwm_stream_if.sink                          req,
   iwm_stream_if.source                        rsp,
   input  logic                                csr_we,
   input  logic [iwm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [iwm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW = $clog2(WINDOW + 1);
   localparam logic [CW-1:0] FULL = CW'(WINDOW);
   localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);
   localparam logic [AW-1:0] MID = AW'(WINDOW / 2);

   iwm_pkg::state_type state_ff, state_in;
   logic [14:0]        xy_lim_ff;
   logic signed [15:0] z_floor_ff;
   logic [14:0]        turn_thr_ff;
   logic [AW-1:0]      oldest_ff, oldest_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [AW-1:0]      a_ff, a_in;
   logic [AW-1:0]      b_ff, b_in;
   logic [AW-1:0]      rank_ff, rank_in;
   logic signed [iwm_pkg::KEY_W-1:0] ka_ff, ka_in;
   logic               busy_cmp_ff, busy_cmp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   iwm_pkg::result_type res_ff, res_in;

   logic               accept;
   logic [AW-1:0]      wr_slot;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      rd_age;
   logic [AW:0]        age_sum;
   iwm_pkg::sample_type in_sample, smp_rd;
   logic signed [iwm_pkg::KEY_W-1:0] key_rd;
   logic               beats;
   logic               tilt, turning;
   logic               fill_full;

   assign in_sample = req.payload;
   assign accept = req.valid && req.ready;
   assign fill_full = fill_ff == FULL;
   assign wr_slot = fill_full ? oldest_ff : fill_ff[AW-1:0];

   // Sample store and key store share address but keys are read while ranking.
   iwm_ram #(.WIDTH(iwm_pkg::SAMPLE_W), .DEPTH(WINDOW)) u_sample_ram (
      .clock(clock), .wr_en(accept), .wr_addr(wr_slot), .wr_data(in_sample),
      .rd_addr(rd_addr), .rd_data(smp_rd));
   iwm_ram #(.WIDTH(iwm_pkg::KEY_W), .DEPTH(WINDOW)) u_key_ram (
      .clock(clock), .wr_en(accept), .wr_addr(wr_slot),
      .wr_data(iwm_pkg::key_of(in_sample)), .rd_addr(rd_addr), .rd_data(key_rd));

   // Age to slot: (oldest + age) mod WINDOW, one conditional subtract.
   always_comb begin
      age_sum = {1'b0, oldest_ff} + {1'b0, rd_age};
      rd_addr = (age_sum >= (AW+1)'(WINDOW)) ? AW'(age_sum - (AW+1)'(WINDOW))
                                             : age_sum[AW-1:0];
   end

   iwm_flags u_flags (
      .sample(smp_rd), .tilt_xy_limit(xy_lim_ff), .tilt_z_floor(z_floor_ff),
      .turn_threshold(turn_thr_ff), .tilt(tilt), .turning(turning));

   // Shared compare: does key at age b rank ahead of candidate at age a.
   assign beats = (key_rd > ka_ff) || ((key_rd == ka_ff) && (b_ff < a_ff));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         xy_lim_ff <= iwm_pkg::TILT_XY_LIMIT_RESET;
         z_floor_ff <= iwm_pkg::TILT_Z_FLOOR_RESET;
         turn_thr_ff <= iwm_pkg::TURN_THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            iwm_pkg::CSR_TILT_XY_LIMIT:  xy_lim_ff <= csr_wdata[14:0];
            iwm_pkg::CSR_TILT_Z_FLOOR:   z_floor_ff <= signed'(csr_wdata);
            iwm_pkg::CSR_TURN_THRESHOLD: turn_thr_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iwm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (fill_ff == FULL - CW'(1) || fill_full) ? iwm_pkg::ST_OUTER
                                                                  : iwm_pkg::ST_RESULT;
            end
         end
         iwm_pkg::ST_OUTER: state_in = iwm_pkg::ST_INNER;
         iwm_pkg::ST_INNER: begin
            if (busy_cmp_ff && b_ff == LAST) begin
               state_in = ((rank_in == MID) || (a_ff == LAST)) ? iwm_pkg::ST_FETCH
                                                               : iwm_pkg::ST_OUTER;
            end
         end
         iwm_pkg::ST_FETCH: state_in = iwm_pkg::ST_RESULT;
         iwm_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) state_in = iwm_pkg::ST_IDLE;
         end
         default: state_in = iwm_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output controls.
   always_comb begin
      oldest_in = oldest_ff;
      fill_in = fill_ff;
      a_in = a_ff;
      b_in = b_ff;
      rank_in = rank_ff;
      ka_in = ka_ff;
      busy_cmp_in = 1'b0;
      rd_age = a_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      req.ready = 1'b0;
      unique case (state_ff)
         iwm_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (accept) begin
               a_in = '0;
               res_in = '0;
               if (fill_full) begin
                  oldest_in = (oldest_ff == LAST) ? '0 : oldest_ff + AW'(1);
               end else begin
                  fill_in = fill_ff + CW'(1);
               end
            end
         end
         iwm_pkg::ST_OUTER: begin
            // Key of candidate arrives next cycle; start the walk.
            rd_age = a_ff;
            b_in = '0;
            rank_in = '0;
         end
         iwm_pkg::ST_INNER: begin
            if (!busy_cmp_ff) begin
               ka_in = key_rd;
               rd_age = '0;
               busy_cmp_in = 1'b1;
            end else begin
               if (beats && b_ff != a_ff) rank_in = rank_ff + AW'(1);
               rd_age = (b_ff == LAST) ? b_ff : b_ff + AW'(1);
               b_in = rd_age;
               busy_cmp_in = b_ff != LAST;
               if (b_ff == LAST && !(rank_in == MID) && a_ff != LAST) a_in = a_ff + AW'(1);
               if (b_ff == LAST && a_ff == LAST && !(rank_in == MID)) a_in = '0;
            end
         end
         iwm_pkg::ST_FETCH: rd_age = a_ff;
         iwm_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               if (fill_full) begin
                  res_in.ready_res = 1'b1;
                  res_in.med_accel_x = smp_rd.accel_x;
                  res_in.med_accel_y = smp_rd.accel_y;
                  res_in.med_accel_z = smp_rd.accel_z;
                  res_in.med_gyro_x = smp_rd.gyro_x;
                  res_in.med_gyro_y = smp_rd.gyro_y;
                  res_in.med_gyro_z = smp_rd.gyro_z;
                  res_in.tilt = tilt;
                  res_in.turning = turning;
               end else begin
                  res_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   // The payload register keeps its value until the next result is loaded.
   iwm_pkg::result_type out_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iwm_pkg::ST_IDLE;
         oldest_ff <= '0;
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
         busy_cmp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         oldest_ff <= oldest_in;
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_cmp_ff <= busy_cmp_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      rank_ff <= rank_in;
      ka_ff <= ka_in;
      res_ff <= res_in;
      if (state_ff == iwm_pkg::ST_RESULT && (!rsp_valid_ff || rsp.ready)) begin
         out_ff <= res_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = out_ff;

   `IWM_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FULL, "fill count past window")
   `IWM_ASSERT_NEXT(a_busy_not_ready, clock, reset, accept, !req.ready, "item taken while ranking")
   `IWM_ASSERT_ALWAYS(a_zero_until_full, clock, reset,
      !(rsp.valid && rsp.payload.ready_res) || fill_full, "result valid before window full")
endmodule
